// ===== rtl/dbr_pkg.sv =====
// Shared types, constants and status codes for the decimal rounding pipeline.
`timescale 1ns / 1ps
package dbr_pkg;

	// Largest scale that the block accepts.
	localparam int MAX_SCALE = 28;
	// One pipeline stage for each 32-bit word of each divide-by-ten pass.
	localparam int WORDS = 3;
	localparam int NUM_STEPS = MAX_SCALE * WORDS;

	// Reciprocal of ten, scaled by 2^35, rounded up.
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;
	// floor(2^32 / 10); 2^32 mod 10 is 6.
	localparam logic [28:0] CHUNK_Q = 29'd429496729;
	localparam logic [3:0] CHUNK_R = 4'd6;

	localparam logic [3:0] DIGIT_HALF = 4'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef struct packed {
		logic [63:0] mantissa_low;
		logic [31:0] mantissa_high;
		logic [7:0] scale_in;
		logic [4:0] tgt_scale;
	} req_t;

	typedef struct packed {
		logic [63:0] mantissa_low_out;
		logic [31:0] mantissa_high_out;
		logic [7:0] scale_out;
		logic [1:0] status;
	} rsp_t;

	// Work carried down the pipeline with each item.
	typedef struct packed {
		logic [95:0] mant;
		logic [7:0] scale;
		logic [4:0] target;
		logic [4:0] steps;
		logic bypass;
		logic [1:0] status;
		logic [3:0] rem;
		logic [3:0] last;
		logic sticky;
	} stage_t;

endpackage

// ===== rtl/dbr_div_stage.sv =====
// One word step of a divide-by-ten pass, with its pipeline register.
`timescale 1ns / 1ps
module dbr_div_stage (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic [4:0] digit,
	input logic [1:0] word,
	input logic vld,
	input dbr_pkg::stage_t din,
	output logic vld_out,
	output dbr_pkg::stage_t dout
);

	logic active;
	logic [31:0] w;
	logic [3:0] r;
	logic [32:0] t;
	logic [64:0] prod;
	logic [29:0] qt;
	logic [3:0] rem_t;
	logic [31:0] q;
	dbr_pkg::stage_t nxt;
	logic vld_q;
	dbr_pkg::stage_t data_q;

	always_comb begin
		active = !din.bypass && (digit < din.steps);
		unique case (word)
			2'd2: w = din.mant[95:64];
			2'd1: w = din.mant[63:32];
			default: w = din.mant[31:0];
		endcase
		r = (word == 2'd2) ? 4'd0 : din.rem;
		// The running remainder times 2^32 contributes r*CHUNK_Q to the
		// quotient and 6*r to the part that is still to be divided.
		t = {1'b0, w} + 33'({29'd0, r} * {29'd0, dbr_pkg::CHUNK_R});
		prod = {32'd0, t} * {33'd0, dbr_pkg::RECIP10};
		qt = prod[64:dbr_pkg::RECIP_SHIFT];
		rem_t = t[3:0] - 4'(qt[3:0] * 4'd10);
		q = 32'({3'd0, r} * {3'd0, dbr_pkg::CHUNK_Q}) + {2'd0, qt};
		nxt = din;
		if (active) begin
			nxt.rem = rem_t;
			unique case (word)
				2'd2: begin
					nxt.mant[95:64] = q;
					nxt.sticky = din.sticky | (din.last != 4'd0);
				end
				2'd1: nxt.mant[63:32] = q;
				default: begin
					nxt.mant[31:0] = q;
					nxt.last = rem_t;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign dout = data_q;

endmodule

// ===== rtl/dbr_round.sv =====
// Final half-to-even rounding step and the result register.
`timescale 1ns / 1ps
module dbr_round (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic vld,
	input dbr_pkg::stage_t din,
	output logic rsp_valid,
	output dbr_pkg::rsp_t rsp
);

	logic up;
	logic [96:0] sum;
	dbr_pkg::rsp_t nxt;
	logic vld_q;
	dbr_pkg::rsp_t rsp_q;

	always_comb begin
		up = (din.last > dbr_pkg::DIGIT_HALF) || ((din.last == dbr_pkg::DIGIT_HALF)
			&& (din.sticky || din.mant[0]));
		sum = {1'b0, din.mant} + {96'd0, up};
		if (din.bypass) begin
			nxt.mantissa_low_out = din.mant[63:0];
			nxt.mantissa_high_out = din.mant[95:64];
			nxt.scale_out = din.scale;
			nxt.status = din.status;
		end else begin
			nxt.mantissa_low_out = sum[63:0];
			nxt.mantissa_high_out = sum[95:64];
			nxt.scale_out = {3'd0, din.target};
			nxt.status = sum[96] ? dbr_pkg::ST_OVF : dbr_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= nxt;
		end
	end

	assign rsp_valid = vld_q;
	assign rsp = rsp_q;

endmodule

// ===== rtl/decimal96_bankers_round.sv =====
// Top level of the 96-bit decimal half-to-even rounding pipeline.
`timescale 1ns / 1ps
// This block rounds a 96-bit unsigned decimal mantissa from scale_in down to
// tgt_scale, dividing by ten once per removed digit and rounding the
// removed digits half to even (the last removed digit decides, then any
// nonzero lower digit, then the parity of the quotient). When scale_in is at
// or below the target the beat passes through unchanged with status OK; when
// it is above the target and above 28 it passes through with status 1; a
// round-up that wraps the mantissa reports status 2. The pipeline takes one
// beat per cycle while no result is held on a stall. Each beat passes 86
// register stages: one entry stage, 84 word stages (28 divide-by-ten passes
// of three 32-bit words, each a 33x32 reciprocal multiply) and one rounding
// stage. A result beat held on a stall delays every beat in flight. The whole
// pipeline holds when the result beat is stalled, so req_stall follows
// rsp_stall whenever a result is waiting.
module decimal96_bankers_round (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input dbr_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output dbr_pkg::rsp_t rsp
);

	logic adv;
	logic pass_low;
	logic range_err;
	dbr_pkg::stage_t entry;
	logic vld_s [0:dbr_pkg::NUM_STEPS];
	dbr_pkg::stage_t pipe_s [0:dbr_pkg::NUM_STEPS];

	// Everything moves together unless a finished result is being held.
	assign adv = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	always_comb begin
		pass_low = req.scale_in <= {3'd0, req.tgt_scale};
		range_err = !pass_low && (req.scale_in > 8'(dbr_pkg::MAX_SCALE));
		entry.mant = {req.mantissa_high, req.mantissa_low};
		entry.scale = req.scale_in;
		entry.target = req.tgt_scale;
		// Only meaningful when the value is not bypassed, and then it is at most 28.
		entry.steps = 5'(req.scale_in - {3'd0, req.tgt_scale});
		entry.bypass = pass_low || range_err;
		entry.status = range_err ? dbr_pkg::ST_RANGE : dbr_pkg::ST_OK;
		entry.rem = 4'd0;
		entry.last = 4'd0;
		entry.sticky = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[0] <= entry;
		end
	end

	// Stage k works on word (2 - k mod 3) of divide-by-ten pass k / 3, most
	// significant word first, so the remainder ripples down one stage at a time.
	for (genvar k = 0; k < dbr_pkg::NUM_STEPS; k++) begin : g_step
		dbr_div_stage u_step (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.digit(5'(k / dbr_pkg::WORDS)),
			.word(2'(dbr_pkg::WORDS - 1 - (k % dbr_pkg::WORDS))),
			.vld(vld_s[k]),
			.din(pipe_s[k]),
			.vld_out(vld_s[k+1]),
			.dout(pipe_s[k+1])
		);
	end

	dbr_round u_round (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.vld(vld_s[dbr_pkg::NUM_STEPS]),
		.din(pipe_s[dbr_pkg::NUM_STEPS]),
		.rsp_valid(rsp_valid),
		.rsp(rsp)
	);

	// An out-of-range scale is only ever reported for a scale above the maximum.
	a_range_scale: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == dbr_pkg::ST_RANGE)
		|-> rsp.scale_out > 8'(dbr_pkg::MAX_SCALE))
		else $error("range status with legal scale");

	// A wrapped round-up leaves an all-zero mantissa.
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == dbr_pkg::ST_OVF)
		|-> (rsp.mantissa_low_out == 64'd0) && (rsp.mantissa_high_out == 32'd0))
		else $error("overflow status with nonzero mantissa");

	// The input side is held exactly while a result waits on a stall.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == (rsp_valid && rsp_stall))
		else $error("input stall does not follow output hold");

	// The status code never takes the unused value.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == dbr_pkg::ST_OK) || (rsp.status == dbr_pkg::ST_RANGE)
		|| (rsp.status == dbr_pkg::ST_OVF))
		else $error("undefined status code");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the 96-bit decimal half-to-even rounding pipeline.
`timescale 1ns / 1ps
module testbench;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	dbr_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	dbr_pkg::rsp_t rsp;

	// Expected result beats, oldest first.
	dbr_pkg::rsp_t rounded_q[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	// When set, the receiver holds off for a long stretch.
	bit hold_rsp = 0;
	localparam int unsigned CYCLE_LIMIT = 400000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	decimal96_bankers_round i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Rounds one request half to even, as the block should.
	function automatic dbr_pkg::rsp_t round_half_even(dbr_pkg::req_t r);
		dbr_pkg::rsp_t o;
		logic [95:0] m;
		logic [3:0] last;
		logic sticky;
		int n;
		m = {r.mantissa_high, r.mantissa_low};
		last = 4'd0;
		sticky = 1'b0;
		if (r.scale_in <= {3'b0, r.tgt_scale} || r.scale_in > dbr_pkg::MAX_SCALE) begin
			o.mantissa_low_out = r.mantissa_low;
			o.mantissa_high_out = r.mantissa_high;
			o.scale_out = r.scale_in;
			o.status = (r.scale_in <= {3'b0, r.tgt_scale}) ? dbr_pkg::ST_OK
				: dbr_pkg::ST_RANGE;
			return o;
		end
		n = r.scale_in - r.tgt_scale;
		for (int i = 0; i < n; i++) begin
			if (last != 4'd0)
				sticky = 1'b1;
			last = 4'(m % 96'd10);
			m = m / 96'd10;
		end
		o.status = dbr_pkg::ST_OK;
		if (last > dbr_pkg::DIGIT_HALF || (last == dbr_pkg::DIGIT_HALF && (sticky || m[0])))
		begin
			m = m + 96'd1;
			if (m == '0)
				o.status = dbr_pkg::ST_OVF;
		end
		o.mantissa_low_out = m[63:0];
		o.mantissa_high_out = m[95:64];
		o.scale_out = {3'b0, r.tgt_scale};
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	// Offers one beat and holds it until accepted; the expectation is queued
	// on the accepting edge.
	task automatic send(dbr_pkg::req_t r, bit has_exp, dbr_pkg::rsp_t e);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		rounded_q.push_back(has_exp ? e : round_half_even(r));
	endtask

	task automatic idle_cycles(int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			req <= '{default: '0};
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (rounded_q.size() != 0)
			@(posedge clk);
	endtask

	// Directed table: request, whether the expectation is typed in, the value.
	typedef struct {
		dbr_pkg::req_t r;
		bit has_exp;
		dbr_pkg::rsp_t e;
	} row_t;
	row_t rows[$];

	function automatic dbr_pkg::req_t mk(logic [95:0] m, logic [7:0] s, logic [4:0] t);
		dbr_pkg::req_t r;
		r.mantissa_low = m[63:0];
		r.mantissa_high = m[95:64];
		r.scale_in = s;
		r.tgt_scale = t;
		return r;
	endfunction

	function automatic dbr_pkg::rsp_t mko(logic [95:0] m, logic [7:0] s, logic [1:0] st);
		dbr_pkg::rsp_t o;
		o.mantissa_low_out = m[63:0];
		o.mantissa_high_out = m[95:64];
		o.scale_out = s;
		o.status = st;
		return o;
	endfunction

	task automatic build_table();
		logic [95:0] ones;
		dbr_pkg::rsp_t none;
		ones = '1;
		none = '0;
		// Pass-through when scale is at or below target, including large scales, or above the maximum.
		rows.push_back('{mk(ones, 8'd0, 5'd0), 1'b1, mko(ones, 8'd0, dbr_pkg::ST_OK)});
		rows.push_back('{mk(96'd123, 8'd255, 5'd31), 1'b0, none});
		rows.push_back('{mk(ones, 8'd31, 5'd31), 1'b1, mko(ones, 8'd31, dbr_pkg::ST_OK)});
		rows.push_back('{mk(96'd7, 8'd3, 5'd28), 1'b1, mko(96'd7, 8'd3, dbr_pkg::ST_OK)});
		// Scale above the maximum gives the range status.
		rows.push_back('{mk(ones, 8'd255, 5'd0), 1'b1,
			mko(ones, 8'd255, dbr_pkg::ST_RANGE)});
		rows.push_back('{mk(96'd5, 8'd29, 5'd0), 1'b1,
			mko(96'd5, 8'd29, dbr_pkg::ST_RANGE)});
		rows.push_back('{mk(96'd5, 8'd29, 5'd28), 1'b1,
			mko(96'd5, 8'd29, dbr_pkg::ST_RANGE)});
		// Ties: even quotient stays, odd rounds up, sticky rounds up.
		rows.push_back('{mk(96'd25, 8'd1, 5'd0), 1'b1, mko(96'd2, 8'd0, dbr_pkg::ST_OK)});
		rows.push_back('{mk(96'd35, 8'd1, 5'd0), 1'b1, mko(96'd4, 8'd0, dbr_pkg::ST_OK)});
		rows.push_back('{mk(96'd251, 8'd2, 5'd0), 1'b1, mko(96'd3, 8'd0, dbr_pkg::ST_OK)});
		rows.push_back('{mk(96'd250, 8'd2, 5'd0), 1'b1, mko(96'd2, 8'd0, dbr_pkg::ST_OK)});
		rows.push_back('{mk(96'd5, 8'd1, 5'd0), 1'b1, mko(96'd0, 8'd0, dbr_pkg::ST_OK)});
		rows.push_back('{mk(96'd26, 8'd1, 5'd0), 1'b1, mko(96'd3, 8'd0, dbr_pkg::ST_OK)});
		rows.push_back('{mk(96'd24, 8'd1, 5'd0), 1'b1, mko(96'd2, 8'd0, dbr_pkg::ST_OK)});
		// Full 28-digit removal and extremes of the mantissa.
		rows.push_back('{mk(ones, 8'd28, 5'd0), 1'b0, none});
		rows.push_back('{mk(ones, 8'd1, 5'd0), 1'b0, none});
		rows.push_back('{mk(96'd0, 8'd28, 5'd0), 1'b1, mko(96'd0, 8'd0, dbr_pkg::ST_OK)});
		rows.push_back('{mk(ones, 8'd28, 5'd27), 1'b0, none});
		rows.push_back('{mk(96'h8000_0000_0000_0000_0000_0000, 8'd15, 5'd3), 1'b0, none});
		rows.push_back('{mk({32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd20, 5'd10), 1'b0, none});
		rows.push_back('{mk(96'd999, 8'd28, 5'd26), 1'b1,
			mko(96'd10, 8'd26, dbr_pkg::ST_OK)});
	endtask

	task automatic random_item();
		dbr_pkg::req_t r;
		int k;
		k = $urandom_range(0, 9);
		r.mantissa_low = rand64();
		r.mantissa_high = $urandom;
		if ($urandom_range(0, 3) == 0)
			r.mantissa_high = $urandom_range(0, 3);
		r.tgt_scale = 5'($urandom_range(0, 28));
		if (k < 7) begin
			// Rounding proper.
			r.scale_in = 8'($urandom_range(r.tgt_scale, 28));
			if (r.scale_in == r.tgt_scale && r.scale_in < 28)
				r.scale_in = r.scale_in + 8'd1;
			else if (r.scale_in == r.tgt_scale)
				r.tgt_scale = 5'($urandom_range(0, 27));
			// Force a trailing tie now and then.
			if ($urandom_range(0, 3) == 0) begin
				logic [95:0] m;
				m = {r.mantissa_high, r.mantissa_low};
				m = (m / 96'd10) * 96'd10 + 96'd5;
				if ($urandom_range(0, 1) == 0 && r.scale_in - r.tgt_scale >= 2)
					m = (m / 96'd100) * 96'd100 + 96'd50;
				r.mantissa_low = m[63:0];
				r.mantissa_high = m[95:64];
			end
		end else if (k == 7) begin
			r.tgt_scale = 5'($urandom_range(0, 31));
			r.scale_in = 8'($urandom_range(0, 255));
		end else if (k == 8) begin
			r.scale_in = 8'($urandom_range(29, 255));
		end else begin
			r.scale_in = 8'($urandom_range(0, r.tgt_scale));
		end
		send(r, 1'b0, '0);
	endtask

	// Receiver: random stalls, plus a long hold-off while hold_rsp is set.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = gap_len();
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_rsp = 0;
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Checker: compares each accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rounded_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat %h", rsp);
			end else begin
				dbr_pkg::rsp_t e;
				e = rounded_q.pop_front();
				if (rsp !== e) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h %h %0d %0d, got %h %h %0d %0d",
							e.mantissa_high_out, e.mantissa_low_out, e.scale_out, e.status,
							rsp.mantissa_high_out, rsp.mantissa_low_out, rsp.scale_out,
							rsp.status);
				end
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		build_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send(rows[i].r, rows[i].has_exp, rows[i].e);
			if ($urandom_range(0, 2) == 0)
				idle_cycles(gap_len());
		end
		// Back-to-back items against a long receiver hold-off fill the pipeline.
		hold_rsp = 1;
		for (int i = 0; i < 150; i++)
			random_item();
		// Pause until every expected result has come.
		drain();
		for (int i = 0; i < 650; i++) begin
			random_item();
			if ($urandom_range(0, 1) == 0 || (i >= 300 && i < 400))
				idle_cycles(gap_len());
		end
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && rounded_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/dbr_pkg.sv
rtl/dbr_div_stage.sv
rtl/dbr_round.sv
rtl/decimal96_bankers_round.sv
test/testbench.sv
